// File: rtl/cmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmf_pkg
// shared types, constants and helpers of the cross morphology filter
// ----------------------------------------------------------------------------
package cmf_pkg;

    localparam int CMF_MAX_WIDTH   = 1024;
    localparam int CMF_PIX_W       = 8;
    localparam int CMF_WIDTH_W     = 11;
    localparam int CMF_HEIGHT_W    = 12;
    localparam int CMF_ROW_W       = 13;
    localparam int CMF_CFG_DATA_W  = 12;
    localparam int CMF_CFG_INDEX_W = 2;
    localparam int CMF_MIN_SIZE    = 3;

    localparam logic [CMF_WIDTH_W-1:0]  CMF_WIDTH_RESET  = 11'd1024;
    localparam logic [CMF_HEIGHT_W-1:0] CMF_HEIGHT_RESET = 12'd1024;

    typedef enum logic
    {
        CMF_OP_PIXEL = 1'b0,
        CMF_OP_FLUSH = 1'b1
    } cmf_opcode_t;

    typedef enum logic
    {
        CMF_MODE_ERODE  = 1'b0,
        CMF_MODE_DILATE = 1'b1
    } cmf_mode_t;

    typedef enum logic [CMF_CFG_INDEX_W-1:0]
    {
        CMF_REG_MODE   = 2'd0,
        CMF_REG_WIDTH  = 2'd1,
        CMF_REG_HEIGHT = 2'd2
    } cmf_reg_index_t;

    typedef struct packed
    {
        cmf_opcode_t          opcode;
        logic [CMF_PIX_W-1:0] pixel_in;
    } cmf_in_t;

    typedef struct packed
    {
        logic [CMF_PIX_W-1:0] pixel_out;
        logic                 frame_last;
    } cmf_out_t;

    // per-item flags carried from position tracking to the window stage
    typedef struct packed
    {
        logic res_valid;
        logic interior;
        logic last;
    } cmf_stage_t;

    // minimum for erosion, maximum for dilation
    function automatic logic [CMF_PIX_W-1:0] cmf_pick
    (
        input cmf_mode_t            mode,
        input logic [CMF_PIX_W-1:0] a,
        input logic [CMF_PIX_W-1:0] b
    );
        logic [CMF_PIX_W-1:0] r;
        if (mode == CMF_MODE_DILATE)
        begin
            r = (a > b) ? a : b;
        end
        else
        begin
            r = (a < b) ? a : b;
        end
        return r;
    endfunction

endpackage

// File: rtl/cmf_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmf_line_store
// two-row line store, one read and one write per cycle, write-first bypass
// ----------------------------------------------------------------------------
module cmf_line_store
    import cmf_pkg::*;
#(
    parameter int DEPTH  = CMF_MAX_WIDTH,
    parameter int DATA_W = 2 * CMF_PIX_W
)
(
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // same-entry read and write in one cycle returns the new data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/cross_morphology_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cross_morphology_filter
// plus-shaped 3x3 grayscale erosion / dilation over a raster pixel stream
// ----------------------------------------------------------------------------
// usage
//   pixel channel: one transfer per raster position (valid / stall); a flush
//   item inside the frame counts as a zero pixel, after the frame it drains
//   result channel: filtered pixel plus frame_last on the frame's final pixel
//   cfg channel: mode, image_width, image_height; cfg_ready is always high,
//   write only while the block is idle, new sizes apply at once
//   each pixel transfer answers for the position one row plus one pixel
//   earlier; a frame therefore needs image_width+1 flush transfers at its end
//   pipeline: a pixel transfer loads the window stage, and the window stage
//   loads the result register when it moves on
//   throughput: one pixel per clock unless a result stall holds it; the line
//   store's separate read and write ports take one read and one write each cycle
//   reset: position counters and window clear, mode erosion, size 1024x1024;
//   line store contents are undefined, no clearing pass
//   result stall: one more pixel is taken into the window stage while a result
//   waits, then pixel_stall rises until the result register drains
// ----------------------------------------------------------------------------
module cross_morphology_filter
    import cmf_pkg::*;
#(
    parameter int MAX_WIDTH = CMF_MAX_WIDTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // pixel stream
    input  logic                       pixel_valid,
    output logic                       pixel_stall,
    input  cmf_in_t                    pixel,
    // result stream
    output logic                       result_valid,
    input  logic                       result_stall,
    output cmf_out_t                   result,
    // configuration writes
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CMF_CFG_INDEX_W-1:0] cfg_index,
    input  logic [CMF_CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int XW = (CW > CMF_WIDTH_W) ? CW : CMF_WIDTH_W;
    localparam int RW = CMF_ROW_W;
    localparam int DW = 2 * CMF_PIX_W;

    // configuration
    cmf_mode_t               mode_reg;
    logic [CMF_WIDTH_W-1:0]  image_width_reg;
    logic [CMF_HEIGHT_W-1:0] image_height_reg;

    // raster position of the next item
    logic [AW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    // window stage
    logic                 s1_valid_reg;
    cmf_stage_t           s1_flags_reg, s0_flags;
    logic [AW-1:0]        s1_addr_reg;
    logic [CMF_PIX_W-1:0] s1_x_reg;

    // window registers: middle row left taps, upper and lower neighbours
    logic [CMF_PIX_W-1:0] win0_reg, win1_reg, up_reg, down_reg;

    // result register
    logic     result_valid_reg;
    cmf_out_t result_reg;

    logic                 accept;
    logic                 s1_adv;
    logic                 res_load;
    logic [CW-1:0]        eff_w, w_m1;
    logic [XW-1:0]        iw_x;
    logic [CMF_HEIGHT_W-1:0] eff_h, h_m1;
    logic                 wrap0;
    logic [AW-1:0]        c0;
    logic [CW-1:0]        c0_x, c1, cc;
    logic [RW-1:0]        r0, cr;
    logic [CMF_PIX_W-1:0] x0;
    logic [DW-1:0]        rd_data;
    logic [CMF_PIX_W-1:0] mem_a, mem_b;
    logic [CMF_PIX_W-1:0] res_pix;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= CMF_MODE_ERODE;
            image_width_reg  <= CMF_WIDTH_RESET;
            image_height_reg <= CMF_HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CMF_REG_MODE:   mode_reg         <= cmf_mode_t'(cfg_data[0]);
                CMF_REG_WIDTH:  image_width_reg  <= cfg_data[CMF_WIDTH_W-1:0];
                CMF_REG_HEIGHT: image_height_reg <= cfg_data[CMF_HEIGHT_W-1:0];
                default:        ;
            endcase
        end
    end

    // effective frame size, clamped
    assign iw_x = XW'(image_width_reg);

    always_comb
    begin
        if (iw_x < XW'(CMF_MIN_SIZE))
        begin
            eff_w = CW'(CMF_MIN_SIZE);
        end
        else if (iw_x > XW'(MAX_WIDTH))
        begin
            eff_w = CW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = iw_x[CW-1:0];
        end
    end

    assign eff_h = (image_height_reg < CMF_HEIGHT_W'(CMF_MIN_SIZE)) ?
                   CMF_HEIGHT_W'(CMF_MIN_SIZE) : image_height_reg;
    assign w_m1  = eff_w - CW'(1);
    assign h_m1  = eff_h - CMF_HEIGHT_W'(1);

    // handshake: the window stage moves on unless its result is blocked
    assign s1_adv      = s1_valid_reg &&
                         (!s1_flags_reg.res_valid || !result_valid_reg || !result_stall);
    assign pixel_stall = s1_valid_reg && !s1_adv;
    assign accept      = pixel_valid && !pixel_stall;
    assign res_load    = s1_adv && s1_flags_reg.res_valid;

    // position tracking for the incoming item
    always_comb
    begin
        // a column beyond a narrowed width wraps to the next row
        wrap0 = CW'(col_reg) >= eff_w;
        c0    = wrap0 ? '0 : col_reg;
        r0    = wrap0 ? (row_reg + RW'(1)) : row_reg;
        c0_x  = CW'(c0);

        s0_flags.res_valid = (r0 > RW'(1)) || ((r0 == RW'(1)) && (c0 != '0));

        // the answered position sits one row and one pixel back
        if (c0 == '0)
        begin
            cr = r0 - RW'(2);
            cc = w_m1;
        end
        else
        begin
            cr = r0 - RW'(1);
            cc = c0_x - CW'(1);
        end

        s0_flags.interior = (cr != '0) && (cr < RW'(h_m1)) && (cc != '0) && (cc < w_m1);
        s0_flags.last     = s0_flags.res_valid && (cr >= RW'(h_m1)) && (cc == w_m1);

        c1 = c0_x + CW'(1);
        if (s0_flags.last)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (c1 >= eff_w)
        begin
            col_next = '0;
            row_next = r0 + RW'(1);
        end
        else
        begin
            col_next = c1[AW-1:0];
            row_next = r0;
        end

        x0 = (pixel.opcode == CMF_OP_FLUSH) ? '0 : pixel.pixel_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_flags_reg <= s0_flags;
            s1_addr_reg  <= c0;
            s1_x_reg     <= x0;
        end
    end

    // line store entry holds {older row, newer row} of one column
    cmf_line_store #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (DW)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (c0),
        .wr_en   (s1_adv),
        .wr_addr (s1_addr_reg),
        .wr_data ({mem_b, s1_x_reg}),
        .rd_data (rd_data)
    );

    assign mem_a = rd_data[DW-1:CMF_PIX_W];
    assign mem_b = rd_data[CMF_PIX_W-1:0];

    // plus-shaped window: centre, left, right, up, down
    always_comb
    begin
        res_pix = win0_reg;
        if (s1_flags_reg.interior)
        begin
            res_pix = cmf_pick(mode_reg, res_pix, win1_reg);
            res_pix = cmf_pick(mode_reg, res_pix, mem_b);
            res_pix = cmf_pick(mode_reg, res_pix, up_reg);
            res_pix = cmf_pick(mode_reg, res_pix, down_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win0_reg <= '0;
            win1_reg <= '0;
            up_reg   <= '0;
            down_reg <= '0;
        end
        else if (s1_adv)
        begin
            win1_reg <= win0_reg;
            win0_reg <= mem_b;
            up_reg   <= mem_a;
            down_reg <= s1_x_reg;
        end
    end

    // result register, holds while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            result_reg.pixel_out  <= res_pix;
            result_reg.frame_last <= s1_flags_reg.last;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
